[hw/rtl/npd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// npd_pkg: shared definitions for the noisy pad detector
// Field widths, configuration register indexes, reset values and the
// verdict record carried through the output queue.
// ----------------------------------------------------------------------------
package npd_pkg;

  // Request field widths
  localparam int unsigned PadW    = 8;
  localparam int unsigned ChargeW = 14;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  localparam int unsigned PermilleW = 10;
  localparam int unsigned RunLimitW = 13;
  localparam int unsigned SatLevelW = 10;
  localparam int unsigned FragLenW  = 13;

  localparam logic [CfgIdxW-1:0] CFG_COUNT_PERMILLE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RUN_LIMIT        = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SATURATION_LEVEL = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FRAGMENT_LENGTH  = 2'd3;

  localparam logic [FragLenW-1:0] FragLenReset = 13'd4000;

  // Share base of the count limit
  localparam int unsigned PermilleBase = 1000;

  // Parameter defaults
  localparam int unsigned NumPadsDefault        = 256;
  localparam int unsigned ChargeFracBitsDefault = 4;
  localparam int unsigned MaxTimebinsDefault    = 8192;

  // One verdict waiting for the sink
  typedef struct packed {
    logic [PadW-1:0] pad;
    logic            noisy;
  } npd_verdict_t;

endpackage
`default_nettype wire

[hw/rtl/npd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// npd_if: valid/ready channels of the noisy pad detector
// npd_in_if carries charge samples, npd_out_if carries pad verdicts.
// ----------------------------------------------------------------------------
interface npd_in_if;
  import npd_pkg::*;

  logic               valid;
  logic               ready;
  logic [PadW-1:0]    pad_index;
  logic [ChargeW-1:0] charge;
  logic               pad_done;

  modport source (output valid, output pad_index, output charge, output pad_done,
                  input ready);
  modport sink   (input valid, input pad_index, input charge, input pad_done,
                  output ready);
endinterface

interface npd_out_if;
  import npd_pkg::*;

  logic            valid;
  logic            ready;
  logic [PadW-1:0] result_pad;
  logic            noisy;

  modport source (output valid, output result_pad, output noisy, input ready);
  modport sink   (input valid, input result_pad, input noisy, output ready);
endinterface
`default_nettype wire

[hw/rtl/npd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// npd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module npd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth)-1:0]         waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic [$clog2(Depth)-1:0]         raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[hw/rtl/noisy_pad_detector_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// noisy_pad_detector_core: per-pad noise verdict over one readout fragment
//
// sample_i takes one sample (pad_index, charge, pad_done) per cycle while ready.
// Per pad the core keeps the nonzero count, current and longest nonzero
// run and the peak charge in one RAM entry. Each request reads its entry,
// updates it in the next cycle and writes it back; a back-to-back request to
// the same pad takes the fresh entry from a forwarding register.
// A request with pad_done pushes one verdict toward verdict_o from stage 1
// and clears the entry. Samples of pads at or above NUM_PADS are accepted
// and dropped. Throughput is one request per cycle while sample_i.ready is high.
// Verdicts queue in a four-entry buffer; sample_i.ready drops only when the
// buffer, counting the verdict in flight, has no slack, so a stalled sink
// back-pressures the input and nothing is lost.
// After reset a clearing pass zeroes the RAM, one entry per cycle; sample_i.ready
// stays low meanwhile, configuration writes are taken. Configuration resets to
// zero, fragment_length to 4000.
// ----------------------------------------------------------------------------
module noisy_pad_detector_core #(
  parameter int unsigned NUM_PADS         = npd_pkg::NumPadsDefault,
  parameter int unsigned CHARGE_FRAC_BITS = npd_pkg::ChargeFracBitsDefault,
  parameter int unsigned MAX_TIMEBINS     = npd_pkg::MaxTimebinsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  npd_in_if.sink                         sample_i,
  npd_out_if.source                      verdict_o,
  input  logic                           cfg_we_i,
  input  logic [npd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [npd_pkg::CfgDataW-1:0]   cfg_data_i
);
  import npd_pkg::*;

  localparam int unsigned AW = $clog2(NUM_PADS);
  localparam int unsigned CW = $clog2(MAX_TIMEBINS);
  localparam int unsigned MW = 3 * CW + ChargeW;
  localparam logic [CW-1:0] CntSat   = CW'(MAX_TIMEBINS - 1);
  localparam logic [AW-1:0] LastAddr = AW'(NUM_PADS - 1);
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam logic [FifoPtrW:0] FifoSlack = (FifoPtrW + 1)'(FifoDepth - 2);

  // Configuration registers
  logic [PermilleW-1:0] count_permille_q;
  logic [RunLimitW-1:0] run_limit_q;
  logic [SatLevelW-1:0] saturation_level_q;
  logic [FragLenW-1:0]  fragment_length_q;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_permille_q   <= '0;
      run_limit_q        <= '0;
      saturation_level_q <= '0;
      fragment_length_q  <= FragLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COUNT_PERMILLE:   count_permille_q   <= cfg_data_i[PermilleW-1:0];
        CFG_RUN_LIMIT:        run_limit_q        <= cfg_data_i[RunLimitW-1:0];
        CFG_SATURATION_LEVEL: saturation_level_q <= cfg_data_i[SatLevelW-1:0];
        CFG_FRAGMENT_LENGTH:  fragment_length_q  <= cfg_data_i[FragLenW-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == LastAddr) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // Output queue state
  npd_verdict_t         fifo_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW:0]    fifo_cnt_q;
  logic                 push, pop;

  // Stage 1 registers (entry read in flight)
  logic               s1_valid_q;
  logic               s1_done_q;
  logic [PadW-1:0]    s1_pad_q;
  logic [ChargeW-1:0] s1_charge_q;
  logic               fwd_q;
  logic [MW-1:0]      fwd_data_q;

  // Stage 0: accept a request, issue the read
  logic          in_range, launch;
  logic [AW-1:0] rd_addr, s1_addr;

  assign sample_i.ready = !clr_q && ((fifo_cnt_q + (FifoPtrW + 1)'(push)) <= FifoSlack);
  assign in_range = 32'(sample_i.pad_index) < NUM_PADS;
  assign launch   = sample_i.valid && sample_i.ready && in_range;
  assign rd_addr  = AW'(sample_i.pad_index);
  assign s1_addr  = AW'(s1_pad_q);

  // Stage 1: modify the entry
  logic [MW-1:0]        rd_data, entry, wr_entry, ram_wdata;
  logic [CW-1:0]        cnt, cur, lng, cnt_n, cur_n, lng_n;
  logic [ChargeW-1:0]   peak, peak_n;
  logic [PermilleW+FragLenW-1:0] limit_prod;
  logic [31:0]          cnt_bound;
  logic                 hit_count, hit_run, unsat, noisy;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;

  assign entry = fwd_q ? fwd_data_q : rd_data;
  assign cnt   = entry[MW-1 -: CW];
  assign cur   = entry[MW-1-CW -: CW];
  assign lng   = entry[ChargeW+CW-1 -: CW];
  assign peak  = entry[ChargeW-1:0];

  always_comb begin
    // Advance the counters, saturating at the top
    if (s1_charge_q != '0) begin
      cnt_n = (cnt == CntSat) ? CntSat : cnt + CW'(1);
      cur_n = (cur == CntSat) ? CntSat : cur + CW'(1);
    end else begin
      cnt_n = cnt;
      cur_n = '0;
    end
    lng_n  = (cur_n > lng) ? cur_n : lng;
    peak_n = (s1_charge_q > peak) ? s1_charge_q : peak;
    // Drop the entry on the pad's last sample
    wr_entry = s1_done_q ? '0 : {cnt_n, cur_n, lng_n, peak_n};
  end

  // Form the verdict: count >= floor(P/1000) <=> P < 1000 * (count + 1)
  assign limit_prod = (PermilleW + FragLenW)'(count_permille_q)
                    * (PermilleW + FragLenW)'(fragment_length_q);
  assign cnt_bound  = 32'(PermilleBase) * (32'(cnt_n) + 32'd1);
  assign hit_count  = (32'(limit_prod) >= 32'(PermilleBase)) && (32'(limit_prod) < cnt_bound);
  assign hit_run    = (run_limit_q != '0) && (32'(lng_n) >= 32'(run_limit_q));
  assign unsat      = (saturation_level_q == '0)
                   || (32'(peak_n) < (32'(saturation_level_q) << CHARGE_FRAC_BITS));
  assign noisy      = unsat && (hit_count || hit_run);

  // Write back, or zero during the clearing pass
  assign ram_we    = clr_q || s1_valid_q;
  assign ram_waddr = clr_q ? clr_addr_q : s1_addr;
  assign ram_wdata = clr_q ? '0 : wr_entry;

  npd_ram #(
    .Width (MW),
    .Depth (NUM_PADS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Advance stage 1 and catch same-pad back-to-back requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_done_q  <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= launch;
      s1_done_q  <= launch && sample_i.pad_done;
      fwd_q      <= launch && s1_valid_q && (rd_addr == s1_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      s1_pad_q    <= sample_i.pad_index;
      s1_charge_q <= sample_i.charge;
    end
    fwd_data_q <= wr_entry;
  end

  // Output queue: push verdicts, pop on sink handshake
  assign push = s1_valid_q && s1_done_q;
  assign pop  = verdict_o.valid && verdict_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + (FifoPtrW + 1)'(push) - (FifoPtrW + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{pad: s1_pad_q, noisy: noisy};
    end
  end

  assign verdict_o.valid      = fifo_cnt_q != '0;
  assign verdict_o.result_pad = fifo_q[rd_ptr_q].pad;
  assign verdict_o.noisy      = fifo_q[rd_ptr_q].noisy;

  // Assertions
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> fifo_cnt_q < (FifoPtrW + 1)'(FifoDepth))
    else $error("verdict queue overflow");

  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !launch)
    else $error("request launched during clearing pass");

  a_fwd_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q && $past(s1_valid_q))
    else $error("forwarding without a preceding write");

  a_push_from_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> $past(launch && sample_i.pad_done))
    else $error("verdict without a last-sample request");

endmodule
`default_nettype wire

[sim/npd_verdict_checker.sv]
// ----------------------------------------------------------------------------
// npd_verdict_checker: verdict scoreboard for the noisy pad detector
// Watches the sample channel, the verdict channel and the configuration
// port. Keeps its own per-pad tallies, predicts one verdict per pad_done
// request and compares every delivered verdict with the oldest prediction.
// ----------------------------------------------------------------------------
module npd_verdict_checker
  import npd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  npd_in_if                   sample_mon,
  npd_out_if                  verdict_mon,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned NumPads    = NumPadsDefault;
  localparam int unsigned FracBits   = ChargeFracBitsDefault;
  localparam int unsigned CntW       = $clog2(MaxTimebinsDefault);
  localparam int unsigned CountSat   = MaxTimebinsDefault - 1;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [CntW-1:0]    hits;
    logic [CntW-1:0]    run;
    logic [CntW-1:0]    best;
    logic [ChargeW-1:0] peak;
  } pad_tally_t;

  pad_tally_t          tally [NumPads];
  logic [PermilleW-1:0] share;
  logic [RunLimitW-1:0] run_lim;
  logic [SatLevelW-1:0] sat_lvl;
  logic [FragLenW-1:0]  frag_len;
  npd_verdict_t        verdicts_due [$];
  int unsigned         fails = 0;

  // Advance a counter, hold it at the top of the range
  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
    return (v >= CntW'(CountSat)) ? CntW'(CountSat) : v + 1'b1;
  endfunction

  // Fold one sample into its pad tally; on the last bin queue the verdict
  function automatic void absorb_sample(input logic [PadW-1:0] pad,
                                        input logic [ChargeW-1:0] q,
                                        input logic last);
    pad_tally_t   t;
    int unsigned  count_limit;
    logic         hit_count;
    logic         hit_run;
    logic         unsaturated;
    npd_verdict_t v;
    if (32'(pad) >= NumPads) return;
    t = tally[pad];
    if (q != '0) begin
      t.hits = bump(t.hits);
      t.run  = bump(t.run);
    end else begin
      t.run = '0;
    end
    if (t.run > t.best) t.best = t.run;
    if (q > t.peak) t.peak = q;
    if (!last) begin
      tally[pad] = t;
      return;
    end
    count_limit = (32'(share) * 32'(frag_len)) / PermilleBase;
    hit_count   = (count_limit != 0) && (32'(t.hits) >= count_limit);
    hit_run     = (run_lim != '0) && (32'(t.best) >= 32'(run_lim));
    unsaturated = (sat_lvl == '0) || (32'(t.peak) < (32'(sat_lvl) << FracBits));
    v.pad   = pad;
    v.noisy = unsaturated && (hit_count || hit_run);
    verdicts_due.push_back(v);
    tally[pad] = '0;
  endfunction

  // Compare a delivered verdict with the oldest prediction
  function automatic void check_verdict(input logic [PadW-1:0] pad, input logic noisy);
    npd_verdict_t want;
    if (verdicts_due.size() == 0) begin
      fails++;
      if (fails <= MaxReports)
        $display("unexpected verdict: pad %0d noisy %0b", pad, noisy);
      return;
    end
    want = verdicts_due.pop_front();
    if (want.pad !== pad || want.noisy !== noisy) begin
      fails++;
      if (fails <= MaxReports)
        $display("verdict mismatch: expected pad %0d noisy %0b, got pad %0d noisy %0b",
                 want.pad, want.noisy, pad, noisy);
    end
  endfunction

  // Track configuration, requests and verdicts at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      share    = '0;
      run_lim  = '0;
      sat_lvl  = '0;
      frag_len = FragLenReset;
      foreach (tally[p]) tally[p] = '0;
      verdicts_due.delete();
    end else begin
      if (verdict_mon.valid && verdict_mon.ready)
        check_verdict(verdict_mon.result_pad, verdict_mon.noisy);
      if (sample_mon.valid && sample_mon.ready)
        absorb_sample(sample_mon.pad_index, sample_mon.charge, sample_mon.pad_done);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COUNT_PERMILLE:   share    = cfg_data_i[PermilleW-1:0];
          CFG_RUN_LIMIT:        run_lim  = cfg_data_i[RunLimitW-1:0];
          CFG_SATURATION_LEVEL: sat_lvl  = cfg_data_i[SatLevelW-1:0];
          CFG_FRAGMENT_LENGTH:  frag_len = cfg_data_i[FragLenW-1:0];
          default: ;
        endcase
      end
    end
    pending_o    = verdicts_due.size();
    fail_count_o = fails;
  end

endmodule

[sim/noisy_pad_detector_core_test.sv]
// ----------------------------------------------------------------------------
// noisy_pad_detector_core_test: stimulus and verdict for the pad detector
// Runs directed pad fragments around the count, run and saturation limits,
// large limits with a share above one thousand and a full share of a longer
// fragment, then interleaved random fragments under changing settings with
// random idling on both channels and one long verdict stall. A separate
// checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module noisy_pad_detector_core_test
  import npd_pkg::*;
;

  localparam int unsigned ClockHalf        = 4;
  localparam int unsigned ResetCycles      = 7;
  localparam int unsigned IdlePct          = 15;
  localparam int unsigned HoldOffCycles    = 300;
  localparam int unsigned PressureItems    = 40;
  localparam int unsigned SettleCycles     = 8;
  localparam int unsigned DrainLimit       = 20000;
  localparam int unsigned TimeoutCycles    = 1000000;
  localparam int unsigned FragSlots        = 4;
  localparam int unsigned NoisePct         = 10;
  localparam int unsigned LongRun          = 40;
  localparam int unsigned RandomPhaseItems = 200;
  localparam int unsigned ChargeMax        = 16383;
  localparam int unsigned ChargeBelowSat   = 16367;

  localparam logic [PadW-1:0] PadRunSat   = 8'd17;
  localparam logic [PadW-1:0] PadCountSat = 8'd18;
  localparam logic [PadW-1:0] PadShareSat = 8'd200;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         fail_count;
  int unsigned         pending;
  bit                  idle_on  = 1'b1;
  bit                  hold_req = 1'b0;

  npd_in_if  sample_if ();
  npd_out_if verdict_if ();

  noisy_pad_detector_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_if),
    .verdict_o  (verdict_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  npd_verdict_checker verdict_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_mon   (sample_if),
    .verdict_mon  (verdict_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(ClockHalf) clk_i = ~clk_i;

  // Abort a hung run
  initial begin
    #(2 * ClockHalf * TimeoutCycles);
    $display("noisy_pad_detector_core test failed");
    $finish;
  end

  // Drain verdicts with random stalls; hold off for a long stretch on request
  initial begin : verdict_sink
    verdict_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        verdict_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        verdict_if.ready <= !(idle_on && ($urandom_range(99) < IdlePct));
      end
    end
  end

  // Draw a charge: zero, tiny, near full scale or anywhere
  function automatic logic [ChargeW-1:0] pick_charge(input int unsigned nz_pct);
    logic [ChargeW-1:0] q;
    q = '0;
    if ($urandom_range(99) < nz_pct) begin
      case ($urandom_range(3))
        0:       q = ChargeW'($urandom_range(1, 15));
        1:       q = ChargeW'($urandom_range(16350, ChargeMax));
        default: q = ChargeW'($urandom_range(1, ChargeMax));
      endcase
    end
    return q;
  endfunction

  // Offer one sample request, with random gaps, and hold it until taken
  task automatic push_sample(input logic [PadW-1:0] pad, input logic [ChargeW-1:0] q,
                             input logic last);
    while (idle_on && ($urandom_range(99) < IdlePct)) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid     <= 1'b1;
    sample_if.pad_index <= pad;
    sample_if.charge    <= q;
    sample_if.pad_done  <= last;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted verdict has come out
  task automatic settle_block();
    int unsigned guard;
    sample_if.valid <= 1'b0;
    guard = 0;
    do begin
      @(negedge clk_i);
      guard++;
    end while (pending != 0 && guard < DrainLimit);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CfgDataW'(value);
    @(posedge clk_i);
  endtask

  // Write all four registers while the block is idle
  task automatic apply_settings(input int unsigned share, input int unsigned run_len,
                                input int unsigned sat_lvl, input int unsigned frag_len);
    settle_block();
    put_reg(CFG_COUNT_PERMILLE, share);
    put_reg(CFG_RUN_LIMIT, run_len);
    put_reg(CFG_SATURATION_LEVEL, sat_lvl);
    put_reg(CFG_FRAGMENT_LENGTH, frag_len);
    cfg_we <= 1'b0;
  endtask

  // Pick limits that a short fragment can reach, sometimes with a large share
  task automatic apply_random_settings();
    int unsigned share;
    int unsigned frag_len;
    int unsigned sat_lvl;
    if ($urandom_range(1)) begin
      share    = $urandom_range(0, 4);
      frag_len = $urandom_range(200, 3000);
    end else begin
      share    = $urandom_range(0, 1000);
      frag_len = $urandom_range(0, 20);
    end
    sat_lvl = $urandom_range(1) ? 0 : $urandom_range(1, 1023);
    apply_settings(share, $urandom_range(0, 10), sat_lvl, frag_len);
  endtask

  // Interleave short pad fragments, with some stray samples mixed in
  task automatic run_fragments(input int unsigned n_items);
    logic [PadW-1:0] slot_pad [FragSlots];
    int unsigned     slot_left [FragSlots];
    int unsigned     slot_pct [FragSlots];
    int unsigned     s;
    for (s = 0; s < FragSlots; s++) slot_left[s] = 0;
    repeat (n_items) begin
      s = $urandom_range(FragSlots - 1);
      if ($urandom_range(99) < NoisePct) begin
        push_sample(PadW'($urandom), pick_charge($urandom_range(100)), 1'($urandom));
      end else begin
        if (slot_left[s] == 0) begin
          slot_pad[s]  = PadW'($urandom);
          slot_left[s] = $urandom_range(1, 24);
          slot_pct[s]  = $urandom_range(0, 100);
        end
        slot_left[s]--;
        push_sample(slot_pad[s], pick_charge(slot_pct[s]), slot_left[s] == 0);
      end
    end
    // Close any fragment still open
    for (s = 0; s < FragSlots; s++)
      if (slot_left[s] != 0) push_sample(slot_pad[s], pick_charge(slot_pct[s]), 1'b1);
  endtask

  initial begin : stimulus
    int unsigned        n;
    logic [ChargeW-1:0] q;
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_data            <= '0;
    sample_if.valid     <= 1'b0;
    sample_if.pad_index <= '0;
    sample_if.charge    <= '0;
    sample_if.pad_done  <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: count limit 4, run limit 3, saturation at full scale
    apply_settings(1, 3, 1023, 4000);
    repeat (2) push_sample(8'd0, ChargeW'(ChargeMax), 1'b0);
    push_sample(8'd0, ChargeW'(ChargeMax), 1'b1);
    push_sample(8'd255, 14'd1, 1'b0);
    push_sample(8'd255, 14'd2, 1'b0);
    push_sample(8'd255, 14'd3, 1'b1);
    push_sample(8'h55, 14'd0, 1'b0);
    push_sample(8'h55, 14'd0, 1'b1);
    repeat (2) push_sample(8'hAA, ChargeW'(ChargeBelowSat), 1'b0);
    push_sample(8'hAA, ChargeW'(ChargeBelowSat), 1'b1);
    repeat (2) push_sample(8'd7, ChargeW'(ChargeBelowSat + 1), 1'b0);
    push_sample(8'd7, ChargeW'(ChargeBelowSat + 1), 1'b1);
    push_sample(8'd9, 14'd5, 1'b0);
    push_sample(8'd9, 14'd0, 1'b0);
    push_sample(8'd9, 14'd5, 1'b0);
    push_sample(8'd9, 14'd0, 1'b0);
    push_sample(8'd9, 14'd5, 1'b0);
    push_sample(8'd9, 14'd5, 1'b1);
    push_sample(8'd12, 14'd0, 1'b1);
    push_sample(8'd13, 14'd1, 1'b1);

    // Everything disabled
    apply_settings(0, 0, 0, 0);
    run_fragments(150);

    // Random settings; one phase without any idling
    for (n = 0; n < 5; n++) begin
      apply_random_settings();
      idle_on = (n != 2);
      run_fragments(RandomPhaseItems);
    end
    idle_on = 1'b1;

    // Stall the verdict side while every request produces a verdict
    apply_settings(2, 4, 0, 2000);
    hold_req = 1'b1;
    repeat (PressureItems) push_sample(PadW'($urandom), pick_charge(70), 1'b1);

    // Largest limits with a share above one thousand: the count limit
    // sits above what the counter can reach
    apply_settings(1023, 8191, 1023, 8191);
    for (n = 0; n < LongRun; n++) begin
      push_sample(PadRunSat, ChargeW'($urandom_range(1, ChargeBelowSat)), n == LongRun - 1);
      q = (n % 10 == 0) ? '0 : ChargeW'($urandom_range(1, ChargeBelowSat));
      push_sample(PadCountSat, q, n == LongRun - 1);
    end

    // Full share: the nonzero count of the fragment just reaches the limit
    apply_settings(1000, 0, 0, LongRun - LongRun / 10);
    for (n = 0; n < LongRun; n++) begin
      q = (n % 10 == 0) ? '0 : ChargeW'($urandom_range(1, ChargeMax));
      push_sample(PadShareSat, q, n == LongRun - 1);
    end

    apply_random_settings();
    run_fragments(100);

    settle_block();
    if (fail_count == 0 && pending == 0) begin
      $display("noisy_pad_detector_core test passed");
    end else begin
      $display("noisy_pad_detector_core test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/npd_pkg.sv
hw/rtl/npd_if.sv
hw/rtl/npd_ram.sv
hw/rtl/noisy_pad_detector_core.sv
sim/npd_verdict_checker.sv
sim/noisy_pad_detector_core_test.sv
